>>> sv/eft_pkg.sv
// ----------------------------------------------------------------------------
// Envelope rise/fall timing package
// Widths, constants, register indexes and shared types for the timing block.
// ----------------------------------------------------------------------------
package eft_pkg;

   localparam int TIME_W        = 32;
   localparam int AMT_W         = 7;
   localparam int SKEW_W        = 8;
   localparam int MARGIN_W      = 24;
   localparam int CSR_IDX_W     = 1;
   localparam int SQ_W          = 17;

   localparam int PDIV_STAGES   = 4;
   localparam int PDIV_BITS     = TIME_W / PDIV_STAGES;
   localparam int RECIP_STAGES  = TIME_W;
   localparam int FALL_STAGES   = 2;
   localparam int LATENCY       = 1 + PDIV_STAGES + 1 + FALL_STAGES + 1 + RECIP_STAGES;

   localparam logic [TIME_W-1:0]   STEP_FULL    = TIME_W'(64'd1 << 31);
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1024);

   localparam logic [TIME_W-1:0] FALL_SK0 = TIME_W'(30);
   localparam logic [TIME_W-1:0] FALL_SK1 = TIME_W'(40);
   localparam logic [TIME_W-1:0] FALL_SK2 = TIME_W'(50);
   localparam logic [TIME_W-1:0] FALL_MIN = TIME_W'(50);
   localparam logic [TIME_W-1:0] FALL_GAP = TIME_W'(20);
   localparam logic [TIME_W-1:0] BIG_D    = TIME_W'(32'hFFFFFF);

   localparam logic [SKEW_W-1:0] SK_LOW_END  = SKEW_W'(25);
   localparam logic [SKEW_W-1:0] SK_HIGH_BEG = SKEW_W'(200);
   localparam logic [SKEW_W-1:0] SK_MID_LO   = SKEW_W'(125);
   localparam logic [SKEW_W-1:0] SK_MID_HI   = SKEW_W'(129);
   localparam logic [SKEW_W-1:0] SK_MAX      = SKEW_W'(255);

   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_ENABLE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_MARGIN = CSR_IDX_W'(1);

   typedef struct packed {
      logic                limit_on;
      logic [MARGIN_W-1:0] margin;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] alt;
      logic              is_div;
      logic [SKEW_W-1:0] sk;
   } dm_side_type;

   typedef struct packed {
      logic [TIME_W-1:0] d;
      logic [TIME_W-1:0] fall;
      logic [TIME_W-1:0] rise;
   } out_side_type;

endpackage

>>> sv/eft_pdiv.sv
// ----------------------------------------------------------------------------
// Small divisor pipelined divider
// Restoring division of the period by a 7-bit magnitude, eight bits a stage.
// ----------------------------------------------------------------------------
module eft_pdiv import eft_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [TIME_W-1:0] num_in,
   input  logic [AMT_W-1:0]  div_in,
   output logic [TIME_W-1:0] quo_out
);

   logic [TIME_W-1:0] num_ff [PDIV_STAGES];
   logic [AMT_W-1:0]  rem_ff [PDIV_STAGES];
   logic [AMT_W-1:0]  div_ff [PDIV_STAGES];
   logic [TIME_W-1:0] num_in_a [PDIV_STAGES];
   logic [AMT_W-1:0]  rem_in_a [PDIV_STAGES];
   logic [AMT_W-1:0]  div_in_a [PDIV_STAGES];

   always_comb begin
      logic [TIME_W-1:0] n;
      logic [AMT_W-1:0]  r;
      logic [AMT_W:0]    t;
      for (int j = 0; j < PDIV_STAGES; j++) begin
         if (j == 0) begin
            n = num_in;
            r = '0;
            div_in_a[j] = div_in;
         end else begin
            n = num_ff[j-1];
            r = rem_ff[j-1];
            div_in_a[j] = div_ff[j-1];
         end
         for (int b = 0; b < PDIV_BITS; b++) begin
            t = {r, n[TIME_W-1]};
            n = {n[TIME_W-2:0], 1'b0};
            if (t >= {1'b0, div_in_a[j]}) begin
               t = t - {1'b0, div_in_a[j]};
               n[0] = 1'b1;
            end
            r = t[AMT_W-1:0];
         end
         num_in_a[j] = n;
         rem_in_a[j] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < PDIV_STAGES; j++) begin
            num_ff[j] <= num_in_a[j];
            rem_ff[j] <= rem_in_a[j];
            div_ff[j] <= div_in_a[j];
         end
      end
   end

   assign quo_out = num_ff[PDIV_STAGES-1];

endmodule

>>> sv/eft_fall.sv
// ----------------------------------------------------------------------------
// Fall time selection
// Forms the skew products and corners, then picks the fall time per mode.
// ----------------------------------------------------------------------------
module eft_fall import eft_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  cfg_type           cfg,
   input  logic [TIME_W-1:0] d_in,
   input  logic [SKEW_W-1:0] sk_in,
   output logic [TIME_W-1:0] d_out,
   output logic [TIME_W-1:0] fall_out
);

   logic [TIME_W-1:0] d_ff, part_ff, mid_ff, dm20_ff, dsq_ff, ud_ff;
   logic [SQ_W-1:0]   sq_lo_ff, sq_hi_ff;
   logic [SKEW_W-1:0] sk_ff;
   logic              lim_ff;
   logic [TIME_W-1:0] d2_ff, fall_ff;

   logic [TIME_W-1:0] p_hi, p_lo, part_in, dm20_in, dsq_in, ud_in;
   logic [SKEW_W-1:0] rev;
   logic [SQ_W-1:0]   sq_lo_in, sq_hi_in;
   logic              lim_in;
   logic [TIME_W-1:0] fall_in, pc, margin_w;

   assign rev      = SK_MAX - sk_in;
   assign p_hi     = {8'd0, d_in[TIME_W-1:8]} * {24'd0, sk_in};
   assign p_lo     = ({8'd0, d_in[23:0]} * {24'd0, sk_in}) >> 8;
   assign part_in  = (d_in > BIG_D) ? p_hi : p_lo;
   assign sq_lo_in = {16'({8'd0, sk_in} * {8'd0, sk_in}), 1'b0};
   assign sq_hi_in = {16'({8'd0, rev} * {8'd0, rev}), 1'b0};
   assign dm20_in  = d_in - FALL_GAP;
   assign dsq_in   = d_in - TIME_W'(sq_hi_in);
   assign ud_in    = d_in - TIME_W'(cfg.margin);
   assign lim_in   = cfg.limit_on && (d_in >= TIME_W'({cfg.margin, 1'b0}));
   assign margin_w = TIME_W'(cfg.margin);

   always_comb begin
      pc = part_ff;
      if (sk_ff > SK_MID_LO && sk_ff <= SK_MID_HI) begin
         fall_in = d_ff >> 1;
      end else if (lim_ff) begin
         if (pc < margin_w) pc = margin_w;
         fall_in = (pc > ud_ff) ? ud_ff : pc;
      end else if (sk_ff == 8'd0) begin
         fall_in = FALL_SK0;
      end else if (sk_ff == 8'd1) begin
         fall_in = FALL_SK1;
      end else if (sk_ff == 8'd2) begin
         fall_in = FALL_SK2;
      end else if (sk_ff <= SK_LOW_END) begin
         if (pc < FALL_MIN) pc = FALL_MIN;
         fall_in = (pc < TIME_W'(sq_lo_ff)) ? pc : TIME_W'(sq_lo_ff);
      end else if (sk_ff == SK_MAX) begin
         fall_in = dm20_ff;
      end else if (sk_ff > SK_HIGH_BEG) begin
         if (pc > dm20_ff) pc = dm20_ff;
         if (TIME_W'(sq_hi_ff) > dm20_ff) fall_in = pc;
         else fall_in = (pc > dsq_ff) ? pc : dsq_ff;
      end else begin
         fall_in = mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff     <= d_in;
         sk_ff    <= sk_in;
         part_ff  <= part_in;
         mid_ff   <= p_hi;
         sq_lo_ff <= sq_lo_in;
         sq_hi_ff <= sq_hi_in;
         dm20_ff  <= dm20_in;
         dsq_ff   <= dsq_in;
         ud_ff    <= ud_in;
         lim_ff   <= lim_in;
         d2_ff    <= d_ff;
         fall_ff  <= fall_in;
      end
   end

   assign d_out    = d2_ff;
   assign fall_out = fall_ff;

endmodule

>>> sv/eft_recip.sv
// ----------------------------------------------------------------------------
// Phase step divider
// Pipelined restoring division of 2^31 by a time, one quotient bit a stage.
// ----------------------------------------------------------------------------
module eft_recip import eft_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [TIME_W-1:0] div_in,
   output logic [TIME_W-1:0] quo_out
);

   logic [TIME_W-1:0] num_ff [RECIP_STAGES];
   logic [TIME_W-1:0] rem_ff [RECIP_STAGES];
   logic [TIME_W-1:0] div_ff [RECIP_STAGES];
   logic [TIME_W-1:0] num_in_a [RECIP_STAGES];
   logic [TIME_W-1:0] rem_in_a [RECIP_STAGES];
   logic [TIME_W-1:0] div_in_a [RECIP_STAGES];

   always_comb begin
      logic [TIME_W-1:0] n;
      logic [TIME_W:0]   t;
      for (int k = 0; k < RECIP_STAGES; k++) begin
         if (k == 0) begin
            n = STEP_FULL;
            t = {{TIME_W{1'b0}}, n[TIME_W-1]};
            div_in_a[k] = div_in;
         end else begin
            n = num_ff[k-1];
            t = {rem_ff[k-1], n[TIME_W-1]};
            div_in_a[k] = div_ff[k-1];
         end
         n = {n[TIME_W-2:0], 1'b0};
         if (t >= {1'b0, div_in_a[k]}) begin
            t = t - {1'b0, div_in_a[k]};
            n[0] = 1'b1;
         end
         num_in_a[k] = n;
         rem_in_a[k] = t[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < RECIP_STAGES; k++) begin
            num_ff[k] <= num_in_a[k];
            rem_ff[k] <= rem_in_a[k];
            div_ff[k] <= div_in_a[k];
         end
      end
   end

   assign quo_out = num_ff[RECIP_STAGES-1];

endmodule

>>> sv/envelope_rise_fall_timing.sv
// ----------------------------------------------------------------------------
// Envelope rise/fall timing
// The pipeline is one input stage, a 4-stage period divider, one select
// stage, 2 fall stages, one rise stage and the 32-stage phase step dividers.
// Throughput is one item per cycle; the whole pipeline holds while a result
// waits. Synchronous reset clears the valid bits and restores the CSR defaults.
// ----------------------------------------------------------------------------
module envelope_rise_fall_timing import eft_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_W-1:0]    req_clock_period,
   input  logic [AMT_W-1:0]     req_divide_amount,
   input  logic [SKEW_W-1:0]    req_skew,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TIME_W-1:0]    rsp_divided_period,
   output logic [TIME_W-1:0]    rsp_fall_ticks,
   output logic [TIME_W-1:0]    rsp_rise_ticks,
   output logic [TIME_W-1:0]    rsp_rise_step,
   output logic [TIME_W-1:0]    rsp_fall_step,
   output logic                 rsp_zero_time_flag,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MARGIN_W-1:0]  csr_write_data
);

   logic              en;
   logic [LATENCY-1:0] vld_ff;
   cfg_type           cfg_ff;

   logic [TIME_W-1:0] s1_period_ff;
   logic [AMT_W-1:0]  s1_mag_ff;
   dm_side_type       s1_side_ff;
   dm_side_type       dm_side_ff [PDIV_STAGES];
   logic [TIME_W-1:0] s6_d_ff;
   logic [SKEW_W-1:0] s6_sk_ff;
   out_side_type      s9_ff;
   out_side_type      out_side_ff [RECIP_STAGES];

   logic              amt_mul, amt_div;
   logic [AMT_W-1:0]  amt_neg;
   logic [TIME_W-1:0] mul_prod;
   dm_side_type       s1_side_in;
   logic [TIME_W-1:0] quo, fall_d, fall_t, rstep_q, fstep_q;
   logic              rise_zero, fall_zero;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LATENCY-1];

   assign amt_mul  = $signed(req_divide_amount) > $signed(AMT_W'(1));
   assign amt_div  = $signed(req_divide_amount) < $signed(-AMT_W'(1));
   assign amt_neg  = ~req_divide_amount + AMT_W'(1);
   assign mul_prod = req_clock_period * {26'd0, req_divide_amount[5:0]};

   always_comb begin
      s1_side_in.alt    = amt_mul ? mul_prod : req_clock_period;
      s1_side_in.is_div = amt_div;
      s1_side_in.sk     = req_skew;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         cfg_ff.limit_on <= 1'b0;
         cfg_ff.margin   <= MARGIN_RESET;
      end else begin
         if (en) vld_ff <= {vld_ff[LATENCY-2:0], req_valid};
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_LIMIT_ENABLE: cfg_ff.limit_on <= csr_write_data[0];
               CSR_LIMIT_MARGIN: cfg_ff.margin   <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_period_ff <= req_clock_period;
         s1_mag_ff    <= amt_neg;
         s1_side_ff   <= s1_side_in;
         dm_side_ff[0] <= s1_side_ff;
         for (int i = 1; i < PDIV_STAGES; i++) dm_side_ff[i] <= dm_side_ff[i-1];
         s6_d_ff  <= dm_side_ff[PDIV_STAGES-1].is_div ? quo : dm_side_ff[PDIV_STAGES-1].alt;
         s6_sk_ff <= dm_side_ff[PDIV_STAGES-1].sk;
         s9_ff.d    <= fall_d;
         s9_ff.fall <= fall_t;
         s9_ff.rise <= fall_d - fall_t;
         out_side_ff[0] <= s9_ff;
         for (int i = 1; i < RECIP_STAGES; i++) out_side_ff[i] <= out_side_ff[i-1];
      end
   end

   eft_pdiv u_pdiv (
      .clock   (clock),
      .en      (en),
      .num_in  (s1_period_ff),
      .div_in  (s1_mag_ff),
      .quo_out (quo)
   );

   eft_fall u_fall (
      .clock    (clock),
      .en       (en),
      .cfg      (cfg_ff),
      .d_in     (s6_d_ff),
      .sk_in    (s6_sk_ff),
      .d_out    (fall_d),
      .fall_out (fall_t)
   );

   eft_recip u_rise_step (
      .clock   (clock),
      .en      (en),
      .div_in  (s9_ff.rise),
      .quo_out (rstep_q)
   );

   eft_recip u_fall_step (
      .clock   (clock),
      .en      (en),
      .div_in  (s9_ff.fall),
      .quo_out (fstep_q)
   );

   assign rise_zero          = out_side_ff[RECIP_STAGES-1].rise == '0;
   assign fall_zero          = out_side_ff[RECIP_STAGES-1].fall == '0;
   assign rsp_divided_period = out_side_ff[RECIP_STAGES-1].d;
   assign rsp_fall_ticks     = out_side_ff[RECIP_STAGES-1].fall;
   assign rsp_rise_ticks     = out_side_ff[RECIP_STAGES-1].rise;
   assign rsp_rise_step      = rise_zero ? STEP_FULL : rstep_q;
   assign rsp_fall_step      = fall_zero ? STEP_FULL : fstep_q;
   assign rsp_zero_time_flag = rise_zero || fall_zero;

endmodule
